// ----- rtl/rmst_pkg.sv -----
// Shared types and constants for the range-minimum segment tree.
package rmst_pkg;

    localparam int POS_W  = 11;   // leaf positions and range bounds
    localparam int CFG_W  = 11;   // leaf count register
    localparam int IN_W   = 32;   // written value as it arrives
    localparam int OUT_W  = 32;   // reported minimum

    localparam logic [CFG_W-1:0] LEAF_COUNT_RESET = 11'd1024;
    localparam logic signed [OUT_W-1:0] EMPTY_MARK = 32'sd1000000000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,   // reset sweep over the node memory
        ST_IDLE,    // waiting for an item
        ST_DESC,    // write: walk from root to the leaf
        ST_ASC,     // write: recompute ancestors on the way up
        ST_QRY,     // query: depth-first walk of the tree
        ST_QDRAIN,  // query: fold the last memory read
        ST_QOUT     // query: hand the result to the output register
    } t_state;

endpackage

// ----- rtl/rmst_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/range_min_segment_tree.sv -----
// Range-minimum segment tree with point writes, built around one node memory.
//
// The block keeps a binary tree of node minima over leaf positions
// 1..leaf_count in a single synchronous RAM of 4*MAX_LEAVES entries (node 1
// is the root, node h has children 2h and 2h+1, split at the midpoint of its
// leaf span). After reset the block runs a clearing pass that writes the empty
// marker 1000000000 into every node, one entry per cycle, before the first
// item is taken; configuration writes are taken during that pass as always.
// A write item (kind 0) walks from the root to its leaf, one level per cycle
// with no memory access, stores the value, then climbs back up, one level per
// cycle, reading the sibling and writing the parent minimum in the same cycle.
// A write to a position of 0 or above leaf_count is dropped. A query item
// (kind 1) walks the tree depth first with a small stack of pending right
// children, one node per cycle; each fully covered node costs one memory read
// whose data is folded the following cycle. A query visits at most about four
// nodes per level; an empty or inverted range answers the empty marker without
// a walk. One item is worked on at a time; the next item is taken as soon as
// the previous one is done, even while the previous result still waits in the
// output register. The user must write leaf_count through the configuration
// channel only while the block is idle; the block itself does not enforce it.
// Node contents are kept across a change of leaf_count and are read under the
// new tree shape. Values keep VALUE_WIDTH bits and are stored at least 32 bits
// wide so the empty marker fits, and min_value reports the low 32 bits.
module range_min_segment_tree
    import rmst_pkg::*;
#(
    parameter int MAX_LEAVES  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // input item channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [IN_W-1:0]  i_value,
    input  logic [POS_W-1:0]        i_range_low,
    input  logic [POS_W-1:0]        i_range_high,
    // result item channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_min_value
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int STORE_W  = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;
    localparam int DEPTH    = 4 * MAX_LEAVES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int POS_MAX  = (1 << POS_W) - 1;
    localparam int LEAF_CAP = (MAX_LEAVES < POS_MAX) ? MAX_LEAVES : POS_MAX;
    localparam int STACK_D  = $clog2(LEAF_CAP) + 1;
    localparam int SP_W     = $clog2(STACK_D + 1);
    localparam int IDX_W    = $clog2(STACK_D);

    localparam logic signed [STORE_W-1:0] EMPTY_S = STORE_W'(EMPTY_MARK);
    localparam logic [ADDR_W-1:0] ROOT      = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                     r_state, n_state;
    logic [CFG_W-1:0]           r_leaf_count, n_leaf_count;
    logic [ADDR_W-1:0]          r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]          r_h, n_h;          // current node
    logic [POS_W-1:0]           r_lo, n_lo;        // its leaf span
    logic [POS_W-1:0]           r_hi, n_hi;
    logic [POS_W-1:0]           r_pos, n_pos;      // leaf being written
    logic [POS_W-1:0]           r_ql, n_ql;        // query range
    logic [POS_W-1:0]           r_qr, n_qr;
    logic signed [STORE_W-1:0]  r_val, n_val;      // value climbing the tree
    logic signed [STORE_W-1:0]  r_acc, n_acc;      // minimum of covered nodes
    logic                       r_acc_ok, n_acc_ok;
    logic                       r_saw_empty, n_saw_empty;
    logic                       r_pend, n_pend;    // read data due this cycle
    logic [SP_W-1:0]            r_sp, n_sp;
    logic [ADDR_W-1:0]          r_stk_h  [STACK_D];
    logic [POS_W-1:0]           r_stk_lo [STACK_D];
    logic [POS_W-1:0]           r_stk_hi [STACK_D];
    logic                       r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0]    r_out_data, n_out_data;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                       w_in_acc;
    logic [POS_W-1:0]           w_leaves;
    logic [POS_W-1:0]           w_mid;
    logic [ADDR_W-1:0]          w_parent;
    logic [ADDR_W-1:0]          w_sibling;
    logic [ADDR_W-1:0]          w_left;
    logic [ADDR_W-1:0]          w_right;
    logic [SP_W-1:0]            w_top;
    logic [IDX_W-1:0]           w_top_idx;
    logic [IDX_W-1:0]           w_push_idx;
    logic                       w_push;
    logic signed [STORE_W-1:0]  w_in_ext;
    logic signed [VALUE_WIDTH-1:0] w_in_trunc;
    logic signed [STORE_W-1:0]  w_in_val;
    logic signed [STORE_W-1:0]  w_rd_data;
    logic signed [STORE_W-1:0]  w_up_min;
    logic signed [STORE_W-1:0]  w_final;
    logic                       w_disjoint;
    logic                       w_covered;

    // memory controls
    logic                       w_wr_en;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic signed [STORE_W-1:0]  w_wr_data;
    logic                       w_rd_en;
    logic [ADDR_W-1:0]          w_rd_addr;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // Clamp the leaf count to what the tree can hold.
    assign w_leaves = (32'(r_leaf_count) > LEAF_CAP) ? POS_W'(LEAF_CAP) : r_leaf_count;

    assign w_mid     = POS_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_parent  = r_h >> 1;
    assign w_sibling = {r_h[ADDR_W-1:1], ~r_h[0]};
    assign w_left    = {r_h[ADDR_W-2:0], 1'b0};
    assign w_right   = {r_h[ADDR_W-2:0], 1'b1};

    assign w_top      = r_sp - SP_W'(1);
    assign w_top_idx  = w_top[IDX_W-1:0];
    assign w_push_idx = r_sp[IDX_W-1:0];

    // Sign-extend the input, keep VALUE_WIDTH bits, extend to storage width.
    assign w_in_ext   = STORE_W'(i_value);
    assign w_in_trunc = w_in_ext[VALUE_WIDTH-1:0];
    assign w_in_val   = STORE_W'(w_in_trunc);

    assign w_up_min = (w_rd_data < r_val) ? w_rd_data : r_val;

    assign w_disjoint = (r_hi < r_ql) || (r_qr < r_lo);
    assign w_covered  = (r_ql <= r_lo) && (r_hi <= r_qr);

    // A disjoint node visited during the walk contributes the empty marker.
    always_comb begin
        if (!r_saw_empty) begin
            w_final = r_acc;
        end else if (r_acc_ok && (r_acc < EMPTY_S)) begin
            w_final = r_acc;
        end else begin
            w_final = EMPTY_S;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_leaf_count = r_leaf_count;
        n_clr_addr   = r_clr_addr;
        n_h          = r_h;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_pos        = r_pos;
        n_ql         = r_ql;
        n_qr         = r_qr;
        n_val        = r_val;
        n_acc        = r_acc;
        n_acc_ok     = r_acc_ok;
        n_saw_empty  = r_saw_empty;
        n_pend       = 1'b0;
        n_sp         = r_sp;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        w_push       = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_h;
        w_wr_data    = r_val;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_h;

        if (i_cfg_valid) begin
            n_leaf_count = i_cfg_data;
        end

        // Drop the result once the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Fold a covered node's value that the memory returns this cycle.
        if (r_pend) begin
            if (!r_acc_ok || (w_rd_data < r_acc)) begin
                n_acc = w_rd_data;
            end
            n_acc_ok = 1'b1;
        end

        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = EMPTY_S;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (w_in_acc) begin
                    n_h  = ROOT;
                    n_lo = POS_W'(1);
                    n_hi = w_leaves;
                    if (i_kind == KIND_WRITE) begin
                        n_pos = i_position;
                        n_val = w_in_val;
                        if ((w_leaves != '0) && (i_position != '0) &&
                            (i_position <= w_leaves)) begin
                            n_state = ST_DESC;
                        end
                    end else begin
                        n_ql        = i_range_low;
                        n_qr        = i_range_high;
                        n_acc_ok    = 1'b0;
                        n_sp        = '0;
                        if ((w_leaves != '0) && (i_range_low <= i_range_high)) begin
                            n_saw_empty = 1'b0;
                            n_state     = ST_QRY;
                        end else begin
                            n_saw_empty = 1'b1;
                            n_state     = ST_QDRAIN;
                        end
                    end
                end
            end

            ST_DESC: begin
                if (r_lo == r_hi) begin
                    // Reached the leaf: store it and start the climb.
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_h;
                    w_wr_data = r_val;
                    if (r_h == ROOT) begin
                        n_state = ST_IDLE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_sibling;
                        n_state   = ST_ASC;
                    end
                end else if (r_pos <= w_mid) begin
                    n_h  = w_left;
                    n_hi = w_mid;
                end else begin
                    n_h  = w_right;
                    n_lo = w_mid + POS_W'(1);
                end
            end

            ST_ASC: begin
                // Sibling arrives; write the parent and fetch its sibling.
                w_wr_en   = 1'b1;
                w_wr_addr = w_parent;
                w_wr_data = w_up_min;
                n_val     = w_up_min;
                n_h       = w_parent;
                if (w_parent == ROOT) begin
                    n_state = ST_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = {w_parent[ADDR_W-1:1], ~w_parent[0]};
                end
            end

            ST_QRY: begin
                if (w_disjoint || w_covered) begin
                    if (w_disjoint) begin
                        n_saw_empty = 1'b1;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_h;
                        n_pend    = 1'b1;
                    end
                    // Advance to the next pending node, or finish.
                    if (r_sp == '0) begin
                        n_state = ST_QDRAIN;
                    end else begin
                        n_h  = r_stk_h[w_top_idx];
                        n_lo = r_stk_lo[w_top_idx];
                        n_hi = r_stk_hi[w_top_idx];
                        n_sp = w_top;
                    end
                end else begin
                    // Partial overlap: hold the right child, go left.
                    w_push = 1'b1;
                    n_sp   = r_sp + SP_W'(1);
                    n_h    = w_left;
                    n_hi   = w_mid;
                end
            end

            ST_QDRAIN: begin
                n_state = ST_QOUT;
            end

            ST_QOUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_final[OUT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_leaf_count <= LEAF_COUNT_RESET;
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_leaf_count <= n_leaf_count;
            r_clr_addr   <= n_clr_addr;
            r_pend       <= n_pend;
            r_sp         <= n_sp;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h         <= n_h;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_pos       <= n_pos;
        r_ql        <= n_ql;
        r_qr        <= n_qr;
        r_val       <= n_val;
        r_acc       <= n_acc;
        r_acc_ok    <= n_acc_ok;
        r_saw_empty <= n_saw_empty;
        r_out_data  <= n_out_data;
        if (w_push) begin
            r_stk_h[w_push_idx]  <= w_right;
            r_stk_lo[w_push_idx] <= w_mid + POS_W'(1);
            r_stk_hi[w_push_idx] <= r_hi;
        end
    end

    // ------------------------------------------------------------------
    // Node memory
    // ------------------------------------------------------------------
    rmst_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_min_value = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_D))
        else $error("query stack overflow");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_rd_en) |-> (w_wr_addr != w_rd_addr))
        else $error("node memory read and write hit the same entry");

    a_climb_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ASC) |-> (r_h > ROOT))
        else $error("climb started at the root");

    a_pend_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == ST_QRY) || (r_state == ST_QDRAIN)))
        else $error("read data folded outside a query");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_QOUT))
        else $error("result raised without a finished query");

endmodule

// ----- tb/sv/range_min_checker.sv -----
`timescale 1ns / 1ps
// Checker for the range-minimum segment tree: mirrors the node minima and checks each answer.
module range_min_checker
    import rmst_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic                    i_kind,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [IN_W-1:0]  i_value,
    input  logic [POS_W-1:0]        i_range_low,
    input  logic [POS_W-1:0]        i_range_high,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [OUT_W-1:0] i_min_value,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int NODE_SLOTS   = 4 * MAX_LEAVES;
    localparam int REPORT_LIMIT = 10;

    logic signed [OUT_W-1:0] node_min [NODE_SLOTS];
    logic [CFG_W-1:0]        leaf_reg;
    logic signed [OUT_W-1:0] awaited_minima [$];
    int                      fail_total = 0;

    function automatic logic signed [OUT_W-1:0] lesser_of(input logic signed [OUT_W-1:0] a,
                                                          input logic signed [OUT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Set one leaf, then refresh every ancestor on the way back up.
    function automatic void tree_store(input int unsigned node, input int unsigned lo,
                                       input int unsigned hi, input int unsigned pos,
                                       input logic signed [OUT_W-1:0] val);
        int unsigned mid;
        if (hi < pos || pos < lo || node >= NODE_SLOTS) begin
            return;
        end
        if (lo == hi) begin
            node_min[node] = val;
            return;
        end
        mid = (lo + hi) / 2;
        tree_store(2 * node, lo, mid, pos, val);
        tree_store(2 * node + 1, mid + 1, hi, pos, val);
        if (2 * node + 1 < NODE_SLOTS) begin
            node_min[node] = lesser_of(node_min[2 * node], node_min[2 * node + 1]);
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] tree_min(input int unsigned node,
                                                         input int unsigned lo,
                                                         input int unsigned hi,
                                                         input int unsigned first,
                                                         input int unsigned last);
        int unsigned mid;
        if (first > last || hi < first || last < lo || node >= NODE_SLOTS) begin
            return EMPTY_MARK;
        end
        if (first <= lo && hi <= last) begin
            return node_min[node];
        end
        mid = (lo + hi) / 2;
        return lesser_of(tree_min(2 * node, lo, mid, first, last),
                         tree_min(2 * node + 1, mid + 1, hi, first, last));
    endfunction

    function automatic void flag_failure(input string what);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    always @(posedge i_clk) begin : track
        logic signed [OUT_W-1:0] want;
        int unsigned             leaves;
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_SLOTS; i++) begin
                node_min[i] = EMPTY_MARK;
            end
            leaf_reg = LEAF_COUNT_RESET;
            awaited_minima.delete();
        end else begin
            // answers leave in query order
            if (i_out_valid && !i_out_stall) begin
                if (awaited_minima.size() == 0) begin
                    flag_failure($sformatf("unexpected result min_value=%0d", i_min_value));
                end else begin
                    want = awaited_minima.pop_front();
                    if (i_min_value !== want) begin
                        flag_failure($sformatf("min_value mismatch: expected %0d, got %0d",
                                               want, i_min_value));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                leaf_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                leaves = (32'(leaf_reg) > MAX_LEAVES) ? MAX_LEAVES : 32'(leaf_reg);
                if (i_kind == KIND_WRITE) begin
                    if (leaves >= 1) begin
                        tree_store(1, 1, leaves, 32'(i_position), i_value);
                    end
                end else begin
                    awaited_minima.push_back((leaves >= 1) ?
                        tree_min(1, 1, leaves, 32'(i_range_low), 32'(i_range_high)) :
                        EMPTY_MARK);
                end
            end
        end
        o_pending    <= awaited_minima.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/sv/tb_range_min_segment_tree.sv -----
`timescale 1ns / 1ps
// Testbench top for the range-minimum segment tree: stimulus, back-pressure and verdict.
module tb_range_min_segment_tree;
    import rmst_pkg::*;

    localparam int MAX_LEAVES       = 1024;
    localparam int RANDOM_ITEMS     = 1600;
    localparam int HOLD_CYCLES      = 400;    // long receiver hold-off that backs up the block
    localparam int SETTLE_CYCLES    = 60;     // longer than a write walk at 1024 leaves
    localparam int DRAIN_LIMIT      = 50000;
    localparam int RUN_LIMIT_CYCLES = 2000000;
    localparam int PRESSURE_PHASE   = 5;
    // Leaf counts visited in turn: the extremes, tiny trees, values above the
    // table size (clamped by the block) and shape changes over old contents.
    localparam int LEAF_SETTINGS [10] = '{1, 0, 2047, 2, 3, 1024, 17, 1025, 600, 1024};

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    item_kind;
    logic [POS_W-1:0]        item_position;
    logic signed [IN_W-1:0]  item_value;
    logic [POS_W-1:0]        item_low;
    logic [POS_W-1:0]        item_high;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] min_value;

    int          fail_count;
    int          pending_results;
    int          hold_asks   = 0;
    int          hold_served = 0;
    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    int unsigned leaf_span;           // leaves in use, only to shape the stimulus

    range_min_segment_tree #(
        .MAX_LEAVES (MAX_LEAVES)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_kind       (item_kind),
        .i_position   (item_position),
        .i_value      (item_value),
        .i_range_low  (item_low),
        .i_range_high (item_high),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_min_value  (min_value)
    );

    range_min_checker #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_kind       (item_kind),
        .i_position   (item_position),
        .i_value      (item_value),
        .i_range_low  (item_low),
        .i_range_high (item_high),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_min_value  (min_value),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high
    // afterwards so back-to-back items need no extra edge; drop it only when
    // a gap is wanted.
    task automatic push_item(input logic k, input logic [POS_W-1:0] pos,
                             input logic signed [IN_W-1:0] val,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        item_kind     <= k;
        item_position <= pos;
        item_value    <= val;
        item_low      <= lo;
        item_high     <= hi;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain the block before touching the register: wait for every answer,
    // then let a trailing write (which gives no answer) finish its climb.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_leaf_count(input int unsigned count);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= count[CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        leaf_span = (count > MAX_LEAVES) ? MAX_LEAVES : count;
    endtask

    // One random item, mostly well formed for the current tree: positions
    // inside the leaves, ordered ranges inside them. The rest probes position
    // zero, positions past the last leaf, inverted and outside ranges, and
    // raw 11-bit noise.
    task automatic random_item();
        logic [POS_W-1:0]       pos;
        logic [POS_W-1:0]       lo;
        logic [POS_W-1:0]       hi;
        logic [POS_W-1:0]       a;
        logic [POS_W-1:0]       b;
        logic signed [IN_W-1:0] val;
        int unsigned            top_leaf;
        top_leaf = (leaf_span == 0) ? 1 : leaf_span;

        case ($urandom_range(0, 9))
            0: begin
                pos = '0;
            end
            1: begin
                pos = POS_W'($urandom_range(0, 2047));
            end
            2: begin
                pos = POS_W'((top_leaf < 2047) ? $urandom_range(top_leaf + 1, 2047) : 2047);
            end
            default: begin
                pos = POS_W'($urandom_range(1, top_leaf));
            end
        endcase

        // keep many values small so narrow ranges still tell leaves apart
        case ($urandom_range(0, 7))
            0, 1: begin
                val = $urandom;
            end
            2: begin
                val = EMPTY_MARK + $urandom_range(0, 2) - 1;
            end
            3: begin
                val = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            4: begin
                val = $urandom_range(0, 15) - 8;
            end
            default: begin
                val = $urandom_range(0, 2000) - 1000;
            end
        endcase

        a = POS_W'($urandom_range(1, top_leaf));
        b = POS_W'($urandom_range(1, top_leaf));
        case ($urandom_range(0, 9))
            0: begin
                lo = POS_W'($urandom_range(0, 2047));
                hi = POS_W'($urandom_range(0, 2047));
            end
            1: begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            2: begin
                lo = a;
                hi = a;
            end
            3: begin
                lo = (a < b) ? a : b;
                hi = lo + POS_W'($urandom_range(0, 7));
            end
            4: begin
                lo = '0;
                hi = a;
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase

        push_item(($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_QUERY, pos, val, lo, hi);
    endtask

    // Result side: random stall runs, and on request one long hold-off counted
    // here in cycles while the sender keeps offering items.
    initial begin : result_sink
        int run;
        forever begin
            if (hold_served != hold_asks) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end else begin
                out_stall <= stalls_on && ($urandom_range(0, 2) == 0);
                run = pick_gap() + 1;
                repeat (run) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int waited;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        item_kind     <= KIND_WRITE;
        item_position <= '0;
        item_value    <= '0;
        item_low      <= '0;
        item_high     <= '0;
        leaf_span = MAX_LEAVES;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset leaf count of 1024. The block's clearing
        // pass holds off the first item; the handshake absorbs that.
        // Query the untouched tree: expect the empty marker.
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd1, 11'd1024);
        // Write the value extremes at both ends and zero in the middle.
        push_item(KIND_WRITE, 11'd1, 32'sh8000_0000, 11'd0, 11'd0);
        push_item(KIND_WRITE, 11'd1024, 32'sh7FFF_FFFF, 11'd0, 11'd0);
        push_item(KIND_WRITE, 11'd512, 32'sd0, 11'd2047, 11'd2047);
        // Drop writes to position zero and past the last leaf.
        push_item(KIND_WRITE, 11'd0, -32'sd5, 11'd1, 11'd1024);
        push_item(KIND_WRITE, 11'd1025, -32'sd6, 11'd1, 11'd1024);
        push_item(KIND_WRITE, 11'd2047, -32'sd7, 11'd1, 11'd1024);
        // Full, partial and clipped ranges; position and value are ignored.
        push_item(KIND_QUERY, 11'd2047, -32'sd1, 11'd1, 11'd1024);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd2, 11'd1024);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd513, 11'd1024);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd1024, 11'd2047);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd0, 11'd2047);
        // Ranges outside the leaves and inverted ranges.
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd0, 11'd0);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd1025, 11'd2047);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd9, 11'd3);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd2047, 11'd0);
        // Overwrite leaf 1 and write leaf 2 with values around the empty marker.
        push_item(KIND_WRITE, 11'd1, 32'sd1000000001, 11'd0, 11'd0);
        push_item(KIND_WRITE, 11'd2, 32'sd999999999, 11'd0, 11'd0);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd1, 11'd1);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd1, 11'd3);
        // Unwritten span, then fill one leaf inside it.
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd3, 11'd511);
        push_item(KIND_WRITE, 11'd300, -32'sd1, 11'd0, 11'd0);
        push_item(KIND_QUERY, 11'd0, 32'sd0, 11'd3, 11'd511);

        // Random phases, one per leaf count. Every third phase runs with no
        // idling on either side; the pressure phase starts with a long
        // receiver hold-off and an eager sender.
        foreach (LEAF_SETTINGS[ph]) begin
            set_leaf_count(LEAF_SETTINGS[ph]);
            gaps_on   = (ph % 3 != 1);
            stalls_on = (ph % 3 != 1);
            if (ph == PRESSURE_PHASE) begin
                gaps_on = 1'b0;
                hold_asks++;
            end
            for (int i = 0; i < RANDOM_ITEMS / $size(LEAF_SETTINGS); i++) begin
                if (ph == PRESSURE_PHASE && i == 60) begin
                    gaps_on = 1'b1;
                end
                random_item();
            end
        end

        // Stop offering, release the receiver and wait for the last answers.
        in_valid <= 1'b0;
        stalls_on = 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending_results != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        repeat (RUN_LIMIT_CYCLES) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule
